>>> src/symbol_error_rate_counter_top_macros.svh
// Assertion macros shared by the symbol error rate counter.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef SYMBOL_ERROR_RATE_COUNTER_TOP_MACROS_SVH
`define SYMBOL_ERROR_RATE_COUNTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SERC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SERC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/serc_pkg.sv
// Shared types and constants of the symbol error rate counter.
// No dependencies; used by the interfaces, the front and back parts and the top level.
package serc_pkg;

	localparam int SYMBOL_WIDTH_DEF   = 32;
	localparam int COUNT_WIDTH_DEF    = 48;
	localparam int RATE_FRAC_BITS_DEF = 31;

	localparam int SYMBOL_FIELD_W = 32;
	localparam int RATE_W         = 32;
	localparam int CFG_INDEX_W    = 2;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic KIND_CLEAR = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ERROR_LIMIT  = 2'd0,
		REG_SYMBOL_LIMIT = 2'd1
	} cfg_reg_t;

	// What the back part does with the rate for one item.
	typedef enum logic [1:0] {
		OP_DIVIDE,
		OP_HOLD,
		OP_ZERO
	} job_op_t;

	typedef struct packed {
		job_op_t op;
		logic    counted;
		logic    mismatch;
		logic    done;
	} job_flags_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_OUT
	} back_state_t;

endpackage

>>> src/serc_if.sv
// Stream interfaces for symbol pairs and result items.
// Depends on serc_pkg for field widths.
interface serc_in_if;
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic [serc_pkg::SYMBOL_FIELD_W-1:0] received_symbol;
	logic [serc_pkg::SYMBOL_FIELD_W-1:0] reference_symbol;

	modport source(output valid, kind, received_symbol, reference_symbol, input ready);
	modport sink(input valid, kind, received_symbol, reference_symbol, output ready);
endinterface

interface serc_out_if #(
	parameter int COUNT_WIDTH = serc_pkg::COUNT_WIDTH_DEF
);
	logic                        valid;
	logic                        ready;
	logic [serc_pkg::RATE_W-1:0] error_rate;
	logic [COUNT_WIDTH-1:0]      symbols_seen;
	logic [COUNT_WIDTH-1:0]      errors_seen;
	logic                        counted;
	logic                        mismatch;
	logic                        done_res;

	modport source(output valid, error_rate, symbols_seen, errors_seen, counted, mismatch,
		done_res, input ready);
	modport sink(input valid, error_rate, symbols_seen, errors_seen, counted, mismatch,
		done_res, output ready);
endinterface

>>> src/serc_front.sv
// Front part: accepts items, holds the limits and the running counts, classifies each item.
// Depends on serc_pkg and serc_in_if.
module serc_front #(
	parameter int SYMBOL_WIDTH = serc_pkg::SYMBOL_WIDTH_DEF,
	parameter int COUNT_WIDTH  = serc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [serc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [COUNT_WIDTH-1:0]           cfg_data,
	serc_in_if.sink                          pairs,
	input  logic                             full,
	output logic                             push,
	output serc_pkg::job_flags_t             job_flags,
	output logic [COUNT_WIDTH-1:0]           job_sym,
	output logic [COUNT_WIDTH-1:0]           job_err
);

	localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

	logic [COUNT_WIDTH-1:0] sym_tot_q, err_tot_q, err_lim_q, sym_lim_q;
	logic [COUNT_WIDTH-1:0] sym_inc, err_inc, sym_nxt, err_nxt;
	logic                   fin_now, fin_nxt, miss;

	assign pairs.ready = !full;
	assign push        = pairs.valid && !full;

	assign miss = pairs.received_symbol[SYMBOL_WIDTH-1:0]
		!= pairs.reference_symbol[SYMBOL_WIDTH-1:0];

	// Both counters stop at their maximum.
	assign sym_inc = (sym_tot_q == CMAX) ? sym_tot_q : sym_tot_q + COUNT_WIDTH'(1);
	assign err_inc = (err_tot_q == CMAX) ? err_tot_q : err_tot_q + COUNT_WIDTH'(1);

	assign fin_now = ((err_lim_q != '0) && (err_tot_q >= err_lim_q))
		|| ((sym_lim_q != '0) && (sym_tot_q >= sym_lim_q));
	assign fin_nxt = ((err_lim_q != '0) && (err_nxt >= err_lim_q))
		|| ((sym_lim_q != '0) && (sym_nxt >= sym_lim_q));

	always_comb begin
		sym_nxt            = sym_tot_q;
		err_nxt            = err_tot_q;
		job_flags.op       = serc_pkg::OP_HOLD;
		job_flags.counted  = 1'b0;
		job_flags.mismatch = 1'b0;
		if (pairs.kind == serc_pkg::KIND_CLEAR) begin
			sym_nxt      = '0;
			err_nxt      = '0;
			job_flags.op = serc_pkg::OP_ZERO;
		end else if (!fin_now) begin
			sym_nxt            = sym_inc;
			err_nxt            = miss ? err_inc : err_tot_q;
			job_flags.op       = serc_pkg::OP_DIVIDE;
			job_flags.counted  = 1'b1;
			job_flags.mismatch = miss;
		end
		job_flags.done = fin_nxt;
	end

	assign job_sym = sym_nxt;
	assign job_err = err_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_tot_q <= '0;
			err_tot_q <= '0;
		end else if (push) begin
			sym_tot_q <= sym_nxt;
			err_tot_q <= err_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_lim_q <= '0;
			sym_lim_q <= '0;
		end else if (cfg_we) begin
			case (serc_pkg::cfg_reg_t'(cfg_index))
				serc_pkg::REG_ERROR_LIMIT:  err_lim_q <= cfg_data;
				serc_pkg::REG_SYMBOL_LIMIT: sym_lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

>>> src/serc_queue.sv
// Short first-in first-out queue between the front and back parts.
// Depends on nothing but its parameters.
module serc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic             nonempty,
	output logic [WIDTH-1:0] dout
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign dout     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> src/serc_back.sv
// Back part: restoring fraction divider for the error rate and the result register.
// Depends on serc_pkg, serc_out_if and the assertion macro header.
`include "symbol_error_rate_counter_top_macros.svh"

module serc_back #(
	parameter int COUNT_WIDTH    = serc_pkg::COUNT_WIDTH_DEF,
	parameter int RATE_FRAC_BITS = serc_pkg::RATE_FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   job_valid,
	input  serc_pkg::job_flags_t   job_flags,
	input  logic [COUNT_WIDTH-1:0] job_sym,
	input  logic [COUNT_WIDTH-1:0] job_err,
	output logic                   pop,
	serc_out_if.source             results
);

	localparam int STEP_W = $clog2(RATE_FRAC_BITS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RATE_FRAC_BITS - 1);
	localparam logic [serc_pkg::RATE_W-1:0] RATE_ONE =
		serc_pkg::RATE_W'(64'd1 << RATE_FRAC_BITS);

	serc_pkg::back_state_t state_q, state_nxt;

	logic [COUNT_WIDTH-1:0]        sym_q, err_q, rem_q, rem_nxt;
	serc_pkg::job_flags_t          flags_q;
	logic [RATE_FRAC_BITS-1:0]     quo_q, quo_nxt;
	logic [STEP_W-1:0]             step_q;
	logic [serc_pkg::RATE_W-1:0]   rate_q;
	logic [COUNT_WIDTH:0]          shifted, diff;
	logic                          ge, all_err;

	// One quotient bit per cycle; the remainder always stays below the divisor.
	assign shifted = {rem_q, 1'b0};
	assign diff    = shifted - {1'b0, sym_q};
	assign ge      = (shifted >= {1'b0, sym_q});
	assign rem_nxt = ge ? diff[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
	assign quo_nxt = {quo_q[RATE_FRAC_BITS-2:0], ge};
	assign all_err = (job_err >= job_sym);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			serc_pkg::BK_IDLE: begin
				if (job_valid) begin
					state_nxt = (job_flags.op == serc_pkg::OP_DIVIDE && !all_err)
						? serc_pkg::BK_DIV : serc_pkg::BK_OUT;
				end
			end
			serc_pkg::BK_DIV: begin
				if (step_q == LAST_STEP) begin
					state_nxt = serc_pkg::BK_OUT;
				end
			end
			serc_pkg::BK_OUT: begin
				if (results.ready) begin
					state_nxt = serc_pkg::BK_IDLE;
				end
			end
			default: state_nxt = serc_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop           = 1'b0;
		results.valid = 1'b0;
		case (state_q)
			serc_pkg::BK_IDLE: pop           = job_valid;
			serc_pkg::BK_OUT:  results.valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= serc_pkg::BK_IDLE;
			rate_q  <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (pop) begin
				step_q <= '0;
				case (job_flags.op)
					serc_pkg::OP_DIVIDE: begin
						if (all_err) begin
							rate_q <= RATE_ONE;
						end
					end
					serc_pkg::OP_ZERO: rate_q <= '0;
					default: ;
				endcase
			end else if (state_q == serc_pkg::BK_DIV) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == LAST_STEP) begin
					rate_q <= serc_pkg::RATE_W'(quo_nxt);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sym_q   <= job_sym;
			err_q   <= job_err;
			flags_q <= job_flags;
			rem_q   <= job_err;
			quo_q   <= '0;
		end else if (state_q == serc_pkg::BK_DIV) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
		end
	end

	assign results.error_rate   = rate_q;
	assign results.symbols_seen = sym_q;
	assign results.errors_seen  = err_q;
	assign results.counted      = flags_q.counted;
	assign results.mismatch     = flags_q.mismatch;
	assign results.done_res     = flags_q.done;

	`SERC_ASSERT_NOW(a_rem_below_divisor, state_q == serc_pkg::BK_DIV, rem_q < sym_q,
		"divider remainder reached the divisor")
	`SERC_ASSERT_NOW(a_rate_at_most_one, results.valid, results.error_rate <= RATE_ONE,
		"error rate above one")
	`SERC_ASSERT_NOW(a_errors_within_symbols, results.valid,
		results.errors_seen <= results.symbols_seen, "more errors than symbols")
	`SERC_ASSERT_NEXT(a_pop_starts_work, pop, state_q != serc_pkg::BK_IDLE,
		"item taken from the queue but back part stayed idle")

endmodule

>>> src/symbol_error_rate_counter_top.sv
// Top level of the symbol error rate counter: front part, item queue and divider back part.
// Depends on serc_pkg, serc_if, serc_front, serc_queue and serc_back.
//
// The block compares aligned received and reference symbols, counts compared symbols and
// mismatches in saturating counters, and returns one result item per input item with the
// error rate errors/symbols as an unsigned fraction with RATE_FRAC_BITS fraction bits
// (truncated, 0 before any symbol is counted, at most 1.0). A clear item zeroes the counts
// and the rate. When a nonzero error or symbol limit is reached the block is finished: pairs
// are then reported with counted low and the counts and rate held, until a clear item. The
// front part counts in the cycle an item is accepted and places it in a two-entry queue, so
// up to two items can be taken while the back part is busy. The back part computes the
// rate with a restoring divider that produces one quotient bit per cycle and takes no new
// item until the result of the last one has been taken; clear items, ignored pairs and
// pairs whose symbols all were errors skip the divider. The result stays in the output
// register until it is taken. Limits are written through the configuration port (index 0
// error limit, index 1 symbol limit, other indexes ignored); the user is to write them only
// while the block is idle, which the block itself does not enforce.
module symbol_error_rate_counter_top #(
	parameter int SYMBOL_WIDTH   = serc_pkg::SYMBOL_WIDTH_DEF,
	parameter int COUNT_WIDTH    = serc_pkg::COUNT_WIDTH_DEF,
	parameter int RATE_FRAC_BITS = serc_pkg::RATE_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [serc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [COUNT_WIDTH-1:0]           cfg_data,
	serc_in_if.sink                          pairs,
	serc_out_if.source                       results
);

	// A queue entry carries the item's flags and its counts after the item.
	localparam int JOB_W = $bits(serc_pkg::job_flags_t) + 2 * COUNT_WIDTH;

	logic                   push, pop, q_full, q_nonempty;
	serc_pkg::job_flags_t   front_flags, back_flags;
	logic [COUNT_WIDTH-1:0] front_sym, front_err, back_sym, back_err;
	logic [JOB_W-1:0]       q_din, q_dout;

	serc_front #(
		.SYMBOL_WIDTH(SYMBOL_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pairs    (pairs),
		.full     (q_full),
		.push     (push),
		.job_flags(front_flags),
		.job_sym  (front_sym),
		.job_err  (front_err)
	);

	assign q_din = {front_flags, front_sym, front_err};

	serc_queue #(
		.WIDTH(JOB_W),
		.DEPTH(serc_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.din     (q_din),
		.full    (q_full),
		.pop     (pop),
		.nonempty(q_nonempty),
		.dout    (q_dout)
	);

	assign {back_flags, back_sym, back_err} = q_dout;

	serc_back #(
		.COUNT_WIDTH   (COUNT_WIDTH),
		.RATE_FRAC_BITS(RATE_FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(q_nonempty),
		.job_flags(back_flags),
		.job_sym  (back_sym),
		.job_err  (back_err),
		.pop      (pop),
		.results  (results)
	);

endmodule
